### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks clocked on clk_i and held off while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_PROP(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: property check failed");

// condition must never be true at a rising edge outside reset
`define ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

### hw/rtl/nmix_pkg.sv
// ---------------------------------------------------------------------------
// nmix_pkg
// widths, codes and types of the mix-minus stereo mixer
// ---------------------------------------------------------------------------
`default_nettype none

package nmix_pkg;

  localparam int unsigned MaxSources   = 16;
  localparam int unsigned SrcBits      = 4;
  localparam int unsigned SampleBits   = 16;
  localparam int unsigned GainBits     = 16;
  localparam int unsigned GainFracBits = 14;
  localparam int unsigned OutBits      = SampleBits + 5;
  localparam int unsigned AccBits      = 40;
  localparam int unsigned CountBits    = 5;
  localparam int unsigned SelfBits     = 5;
  localparam int unsigned MaskBits     = 16;
  localparam int unsigned MgBits       = 16;

  // stream payload widths
  localparam int unsigned InFieldBits  = SrcBits + 2 * SampleBits + 2 * GainBits;
  localparam int unsigned InDataBits   = ((InFieldBits + 7) / 8) * 8;
  localparam int unsigned OutFieldBits = 2 * OutBits + CountBits;
  localparam int unsigned OutDataBits  = ((OutFieldBits + 7) / 8) * 8;

  // configuration port
  localparam int unsigned CfgIdxBits   = 3;
  localparam int unsigned CfgDataBits  = 16;

  // products and frame-end scaling
  localparam int unsigned ProdBits     = SampleBits + GainBits + 1;
  localparam int unsigned LoBits       = 16;
  localparam int unsigned HiBits       = AccBits - LoBits;
  localparam int unsigned PloBits      = LoBits + MgBits + 1;
  localparam int unsigned PhiBits      = HiBits + MgBits;
  localparam int unsigned VBits        = AccBits + MgBits + 1;
  localparam int unsigned RndShift     = 2 * GainFracBits;
  localparam int unsigned RBits        = VBits - RndShift;

  localparam logic [PloBits-1:0]   RndConst   = PloBits'(1) << (RndShift - 1);
  localparam logic [GainBits-1:0]  GainUnity  = GainBits'(1) << GainFracBits;
  localparam int                   ClampMax   = 1 << (SampleBits - 1);
  localparam int                   OutMax     = (1 << (OutBits - 1)) - 1;
  localparam logic [CountBits-1:0] CountMax   = '1;

  // register reset values
  localparam logic [SelfBits-1:0]  SelfReset  = SelfBits'(MaxSources);
  localparam logic [MgBits-1:0]    MgReset    = MgBits'(16384);

  typedef enum logic {
    CMD_SAMPLE     = 1'b0,
    CMD_GAIN_WRITE = 1'b1
  } cmd_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_SELF_INDEX   = 3'd0,
    CFG_ACTIVE_MASK  = 3'd1,
    CFG_MUTE_MASK    = 3'd2,
    CFG_MASTER_GAIN  = 3'd3,
    CFG_CLAMP_ENABLE = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [GainBits-1:0] right;
    logic [GainBits-1:0] left;
  } gain_pair_t;

  typedef struct packed {
    logic                      sat;
    logic signed [OutBits-1:0] val;
  } clip_t;

endpackage

`default_nettype wire

### hw/rtl/n_minus_one_stereo_mixer.sv
// ---------------------------------------------------------------------------
// n_minus_one_stereo_mixer
// mix-minus stereo mixer: per-source gain table in a synchronous memory,
// gained samples summed into 40-bit accumulators, scaled and limited per frame
// ---------------------------------------------------------------------------
//
//  channel  direction  handshake                       payload
//  s_axis   in         s_axis_tvalid / s_axis_tready   tdata, tuser = cmd, tlast = frame_end
//  m_axis   out        m_axis_tvalid / m_axis_tready   tdata, tuser = saturated
//  cfg      in         cfg_valid_i / cfg_ready_o       cfg_index_i, cfg_data_i
//
//  a sample or gain-write item without tlast leaves the input open; items stream back to back
//  an item with tlast closes the input through gain read and multiply, accumulate,
//  low and high partial products of the master gain and output load, plus any wait
//  for the output register to drain; the two-step master-gain scaler sets this
//  reset clears the gain-table valid bits, so every entry reads as unity gain
//  until written; no clearing pass is needed
//  the output register lets a finished frame wait while the next frame streams in
`default_nettype none
`include "assert_macros.svh"

module n_minus_one_stereo_mixer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: source, left_sample, right_sample, gain_left, gain_right, zero fill
  input  logic [nmix_pkg::InDataBits-1:0]      s_axis_tdata,
  // tuser: cmd
  input  logic                                 s_axis_tuser,
  // tlast: frame_end
  input  logic                                 s_axis_tlast,
  // output stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: mix_left, mix_right, summed_count, zero fill
  output logic [nmix_pkg::OutDataBits-1:0]     m_axis_tdata,
  // tuser: saturated
  output logic                                 m_axis_tuser,
  // configuration writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [nmix_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [nmix_pkg::CfgDataBits-1:0]     cfg_data_i
);

  // finisher states
  localparam logic [1:0] FinIdle = 2'd0;
  localparam logic [1:0] FinLo   = 2'd1;
  localparam logic [1:0] FinHi   = 2'd2;
  localparam logic [1:0] FinOut  = 2'd3;

  // ------------------------------------------------------------------
  // input unpacking
  // ------------------------------------------------------------------
  logic                                   in_xfer;
  logic [nmix_pkg::SrcBits-1:0]           in_src;
  logic [nmix_pkg::SampleBits-1:0]        in_left;
  logic [nmix_pkg::SampleBits-1:0]        in_right;
  logic [nmix_pkg::GainBits-1:0]          in_gl;
  logic [nmix_pkg::GainBits-1:0]          in_gr;
  logic                                   in_gain_wr;

  localparam int unsigned LeftLsb  = nmix_pkg::SrcBits;
  localparam int unsigned RightLsb = LeftLsb + nmix_pkg::SampleBits;
  localparam int unsigned GlLsb    = RightLsb + nmix_pkg::SampleBits;
  localparam int unsigned GrLsb    = GlLsb + nmix_pkg::GainBits;

  assign in_src     = s_axis_tdata[nmix_pkg::SrcBits-1:0];
  assign in_left    = s_axis_tdata[LeftLsb +: nmix_pkg::SampleBits];
  assign in_right   = s_axis_tdata[RightLsb +: nmix_pkg::SampleBits];
  assign in_gl      = s_axis_tdata[GlLsb +: nmix_pkg::GainBits];
  assign in_gr      = s_axis_tdata[GrLsb +: nmix_pkg::GainBits];
  assign in_gain_wr = (s_axis_tuser == nmix_pkg::CMD_GAIN_WRITE);

  // a frame end is in flight from its transfer until its result is registered
  logic fend_busy_q;
  assign s_axis_tready = !fend_busy_q;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // ------------------------------------------------------------------
  // configuration registers
  // ------------------------------------------------------------------
  logic [nmix_pkg::SelfBits-1:0] self_q;
  logic [nmix_pkg::MaskBits-1:0] active_q;
  logic [nmix_pkg::MaskBits-1:0] mute_q;
  logic [nmix_pkg::MgBits-1:0]   mgain_q;
  logic                          clamp_q;

  // writes are to come only while the block is idle; it does not enforce this; the port is always open
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_q   <= nmix_pkg::SelfReset;
      active_q <= '0;
      mute_q   <= '0;
      mgain_q  <= nmix_pkg::MgReset;
      clamp_q  <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        nmix_pkg::CFG_SELF_INDEX:   self_q   <= cfg_data_i[nmix_pkg::SelfBits-1:0];
        nmix_pkg::CFG_ACTIVE_MASK:  active_q <= cfg_data_i[nmix_pkg::MaskBits-1:0];
        nmix_pkg::CFG_MUTE_MASK:    mute_q   <= cfg_data_i[nmix_pkg::MaskBits-1:0];
        nmix_pkg::CFG_MASTER_GAIN:  mgain_q  <= cfg_data_i[nmix_pkg::MgBits-1:0];
        nmix_pkg::CFG_CLAMP_ENABLE: clamp_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // gain table: synchronous memory, read registered, valid bit per entry
  // ------------------------------------------------------------------
  nmix_pkg::gain_pair_t              gain_mem [nmix_pkg::MaxSources];
  nmix_pkg::gain_pair_t              rd_q;
  logic [nmix_pkg::MaxSources-1:0]   gvalid_q;

  // a write lands at the transfer edge; the next item's read sees it
  always_ff @(posedge clk_i) begin
    if (in_xfer && in_gain_wr) begin
      gain_mem[in_src] <= '{right: in_gr, left: in_gl};
    end
    if (in_xfer) begin
      rd_q <= gain_mem[in_src];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gvalid_q <= '0;
    end else if (in_xfer && in_gain_wr) begin
      gvalid_q[in_src] <= 1'b1;
    end
  end

  // ------------------------------------------------------------------
  // stage a: gain read back, skip decision, multiply
  // ------------------------------------------------------------------
  logic                            a_valid_q;
  logic                            a_gain_wr_q;
  logic                            a_fend_q;
  logic                            a_gvld_q;
  logic [nmix_pkg::SrcBits-1:0]    a_src_q;
  logic [nmix_pkg::SampleBits-1:0] a_left_q;
  logic [nmix_pkg::SampleBits-1:0] a_right_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      a_gain_wr_q <= in_gain_wr;
      a_fend_q    <= s_axis_tlast;
      a_gvld_q    <= gvalid_q[in_src];
      a_src_q     <= in_src;
      a_left_q    <= in_left;
      a_right_q   <= in_right;
    end
  end

  logic [nmix_pkg::GainBits-1:0]        gain_l;
  logic [nmix_pkg::GainBits-1:0]        gain_r;
  logic                                 a_use;
  logic signed [nmix_pkg::ProdBits-1:0] prod_l;
  logic signed [nmix_pkg::ProdBits-1:0] prod_r;

  // entries never written read as unity
  assign gain_l = a_gvld_q ? rd_q.left  : nmix_pkg::GainUnity;
  assign gain_r = a_gvld_q ? rd_q.right : nmix_pkg::GainUnity;

  assign a_use = a_valid_q && !a_gain_wr_q
              && ({1'b0, a_src_q} != self_q)
              && active_q[a_src_q] && !mute_q[a_src_q]
              && ((gain_l != '0) || (gain_r != '0));

  assign prod_l = $signed(a_left_q)  * $signed({1'b0, gain_l});
  assign prod_r = $signed(a_right_q) * $signed({1'b0, gain_r});

  // ------------------------------------------------------------------
  // stage b: saturating accumulate, source count
  // ------------------------------------------------------------------
  logic                                 b_valid_q;
  logic                                 b_add_q;
  logic                                 b_fend_q;
  logic signed [nmix_pkg::ProdBits-1:0] b_pl_q;
  logic signed [nmix_pkg::ProdBits-1:0] b_pr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      b_add_q   <= 1'b0;
      b_fend_q  <= 1'b0;
    end else begin
      b_valid_q <= a_valid_q;
      b_add_q   <= a_use;
      b_fend_q  <= a_valid_q && a_fend_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_use) begin
      b_pl_q <= prod_l;
      b_pr_q <= prod_r;
    end
  end

  function automatic logic signed [nmix_pkg::AccBits-1:0] sat_add(
    input logic signed [nmix_pkg::AccBits-1:0]  acc,
    input logic signed [nmix_pkg::ProdBits-1:0] p
  );
    logic signed [nmix_pkg::AccBits:0]   s;
    logic signed [nmix_pkg::AccBits-1:0] res;
    s = (nmix_pkg::AccBits + 1)'(acc) + (nmix_pkg::AccBits + 1)'(p);
    if (s[nmix_pkg::AccBits] != s[nmix_pkg::AccBits-1]) begin
      res = s[nmix_pkg::AccBits] ? {1'b1, {(nmix_pkg::AccBits - 1){1'b0}}}
                                 : {1'b0, {(nmix_pkg::AccBits - 1){1'b1}}};
    end else begin
      res = s[nmix_pkg::AccBits-1:0];
    end
    return res;
  endfunction

  logic signed [nmix_pkg::AccBits-1:0] sum_l_q;
  logic signed [nmix_pkg::AccBits-1:0] sum_r_q;
  logic [nmix_pkg::CountBits-1:0]      cnt_q;
  logic signed [nmix_pkg::AccBits-1:0] acc_l;
  logic signed [nmix_pkg::AccBits-1:0] acc_r;
  logic [nmix_pkg::CountBits-1:0]      cnt_new;

  assign acc_l   = b_add_q ? sat_add(sum_l_q, b_pl_q) : sum_l_q;
  assign acc_r   = b_add_q ? sat_add(sum_r_q, b_pr_q) : sum_r_q;
  // count holds at its ceiling
  assign cnt_new = (b_add_q && (cnt_q != nmix_pkg::CountMax)) ? cnt_q + 1'b1 : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_l_q <= '0;
      sum_r_q <= '0;
      cnt_q   <= '0;
    end else if (b_valid_q) begin
      if (b_fend_q) begin
        // frame totals move to the finisher, next frame starts from zero
        sum_l_q <= '0;
        sum_r_q <= '0;
        cnt_q   <= '0;
      end else begin
        sum_l_q <= acc_l;
        sum_r_q <= acc_r;
        cnt_q   <= cnt_new;
      end
    end
  end

  // ------------------------------------------------------------------
  // finisher: master gain in two partial products, round, limit
  // ------------------------------------------------------------------
  logic [1:0]                           fin_st_q;
  logic signed [nmix_pkg::AccBits-1:0]  fin_l_q;
  logic signed [nmix_pkg::AccBits-1:0]  fin_r_q;
  logic [nmix_pkg::CountBits-1:0]       fin_cnt_q;
  logic [nmix_pkg::PloBits-1:0]         plo_l_q;
  logic [nmix_pkg::PloBits-1:0]         plo_r_q;
  logic signed [nmix_pkg::PhiBits-1:0]  phi_l_q;
  logic signed [nmix_pkg::PhiBits-1:0]  phi_r_q;

  // output register
  logic                                 out_valid_q;
  logic signed [nmix_pkg::OutBits-1:0]  out_l_q;
  logic signed [nmix_pkg::OutBits-1:0]  out_r_q;
  logic [nmix_pkg::CountBits-1:0]       out_cnt_q;
  logic                                 out_sat_q;
  logic                                 out_load;

  assign out_load = (fin_st_q == FinOut) && (!out_valid_q || m_axis_tready);

  // low part carries the rounding half so the final step is a single add
  logic [nmix_pkg::PloBits-1:0]        plo_l;
  logic [nmix_pkg::PloBits-1:0]        plo_r;
  logic signed [nmix_pkg::PhiBits-1:0] phi_l;
  logic signed [nmix_pkg::PhiBits-1:0] phi_r;

  assign plo_l = nmix_pkg::PloBits'(fin_l_q[nmix_pkg::LoBits-1:0])
               * nmix_pkg::PloBits'(mgain_q) + nmix_pkg::RndConst;
  assign plo_r = nmix_pkg::PloBits'(fin_r_q[nmix_pkg::LoBits-1:0])
               * nmix_pkg::PloBits'(mgain_q) + nmix_pkg::RndConst;
  assign phi_l = $signed(fin_l_q[nmix_pkg::AccBits-1:nmix_pkg::LoBits])
               * $signed({1'b0, mgain_q});
  assign phi_r = $signed(fin_r_q[nmix_pkg::AccBits-1:nmix_pkg::LoBits])
               * $signed({1'b0, mgain_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_st_q <= FinIdle;
    end else begin
      unique case (fin_st_q)
        FinIdle: if (b_valid_q && b_fend_q) fin_st_q <= FinLo;
        FinLo:   fin_st_q <= FinHi;
        FinHi:   fin_st_q <= FinOut;
        FinOut:  if (out_load) fin_st_q <= FinIdle;
        default: fin_st_q <= FinIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_valid_q && b_fend_q) begin
      fin_l_q   <= acc_l;
      fin_r_q   <= acc_r;
      fin_cnt_q <= cnt_new;
    end
    if (fin_st_q == FinLo) begin
      plo_l_q <= plo_l;
      plo_r_q <= plo_r;
    end
    if (fin_st_q == FinHi) begin
      phi_l_q <= phi_l;
      phi_r_q <= phi_r;
    end
  end

  // recombine, floor shift by the two fraction widths, then limit
  function automatic nmix_pkg::clip_t finish(
    input logic signed [nmix_pkg::PhiBits-1:0] phi,
    input logic [nmix_pkg::PloBits-1:0]        plo,
    input logic                                clamp
  );
    logic signed [nmix_pkg::VBits-1:0] v;
    logic signed [nmix_pkg::RBits-1:0] r;
    logic signed [nmix_pkg::RBits-1:0] hi;
    logic signed [nmix_pkg::RBits-1:0] lo;
    nmix_pkg::clip_t                   res;
    v  = $signed({phi[nmix_pkg::PhiBits-1], phi, {nmix_pkg::LoBits{1'b0}}})
       + $signed({{(nmix_pkg::VBits - nmix_pkg::PloBits){1'b0}}, plo});
    r  = v[nmix_pkg::VBits-1:nmix_pkg::RndShift];
    hi = clamp ? nmix_pkg::RBits'(nmix_pkg::ClampMax) : nmix_pkg::RBits'(nmix_pkg::OutMax);
    lo = clamp ? -nmix_pkg::RBits'(nmix_pkg::ClampMax)
               : -nmix_pkg::RBits'(nmix_pkg::OutMax) - nmix_pkg::RBits'(1);
    if (r > hi) begin
      res.sat = 1'b1;
      res.val = hi[nmix_pkg::OutBits-1:0];
    end else if (r < lo) begin
      res.sat = 1'b1;
      res.val = lo[nmix_pkg::OutBits-1:0];
    end else begin
      res.sat = 1'b0;
      res.val = r[nmix_pkg::OutBits-1:0];
    end
    return res;
  endfunction

  nmix_pkg::clip_t clip_l;
  nmix_pkg::clip_t clip_r;

  assign clip_l = finish(phi_l_q, plo_l_q, clamp_q);
  assign clip_r = finish(phi_r_q, plo_r_q, clamp_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      fend_busy_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (in_xfer && s_axis_tlast) begin
        fend_busy_q <= 1'b1;
      end else if (out_load) begin
        fend_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_l_q   <= clip_l.val;
      out_r_q   <= clip_r.val;
      out_cnt_q <= fin_cnt_q;
      out_sat_q <= clip_l.sat || clip_r.sat;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = nmix_pkg::OutDataBits'({out_cnt_q, out_r_q, out_l_q});
  assign m_axis_tuser  = out_sat_q;

  // ------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------
  // the finisher only runs for a frame end that holds the input closed
  `ASSERT_PROP(a_fin_holds_input, (fin_st_q != FinIdle) |-> fend_busy_q)
  // a new result appears only out of the finisher's last step
  `ASSERT_PROP(a_out_from_fin, $rose(m_axis_tvalid) |-> $past(fin_st_q == FinOut))
  // with clamping on, a delivered sample stays within full scale
  `ASSERT_NEVER(a_clamp_range, m_axis_tvalid && clamp_q
                && (out_l_q > nmix_pkg::ClampMax || out_l_q < -nmix_pkg::ClampMax
                    || out_r_q > nmix_pkg::ClampMax || out_r_q < -nmix_pkg::ClampMax))

endmodule

`default_nettype wire
